// ----- design/nibble_huffman_bit_packer_defines.svh -----
// assertion helpers for the nibble huffman bit packer
`ifndef NIBBLE_HUFFMAN_BIT_PACKER_DEFINES_SVH
`define NIBBLE_HUFFMAN_BIT_PACKER_DEFINES_SVH

// same-cycle implication, checked at every clock edge outside reset
`define NHBP_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nhbp assertion failed");

// next-cycle implication
`define NHBP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nhbp assertion failed");

`endif

// ----- design/nhbp_pkg.sv -----
package nhbp_pkg;

    localparam int BLOCK_BYTES_DEF = 64;

    localparam int BYTE_W  = 8;
    localparam int CODE_W  = 16;
    localparam int LEN_W   = 5;
    localparam int NBITS_W = 10;
    localparam int BCNT_W  = 7;
    localparam int ENTRY_W = CODE_W + LEN_W;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_ENCODE = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    localparam logic REG_EOF_CODE = 1'b0;
    localparam logic REG_EOF_LEN  = 1'b1;

    // control from the sequencer to the bit packer
    typedef struct packed {
        logic              load;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        logic              clear;
        logic              rd;
        logic [BCNT_W-1:0] rd_idx;
    } t_pack_cmd;

    typedef struct packed {
        logic [NBITS_W-1:0] nbits;
        logic               busy;
        logic [BYTE_W-1:0]  acc;
        logic [BYTE_W-1:0]  rd_data;
    } t_pack_stat;

endpackage

// ----- design/nhbp_packer.sv -----
module nhbp_packer #(
    parameter int BLOCK_BYTES = nhbp_pkg::BLOCK_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  nhbp_pkg::t_pack_cmd    i_cmd,
    output nhbp_pkg::t_pack_stat   o_stat
);
    import nhbp_pkg::*;

    localparam int AW = $clog2(BLOCK_BYTES);

    logic [BYTE_W-1:0]  r_mem [BLOCK_BYTES];
    logic [BYTE_W-1:0]  r_rd_data;
    logic [CODE_W-1:0]  r_code;
    logic [LEN_W-1:0]   r_rem;
    logic [BYTE_W-1:0]  r_acc;
    logic [NBITS_W-1:0] r_nbits;

    logic [3:0]         k;
    logic [LEN_W-1:0]   shamt;
    logic [31:0]        wide;
    logic [BYTE_W-1:0]  mask;
    logic [BYTE_W-1:0]  chunk;
    logic [2:0]         fill;
    logic [4:0]         place;
    logic [15:0]        window;
    logic               full_byte;
    logic [BCNT_W-1:0]  byte_idx;
    logic               wr_en;

    // up to eight code bits per cycle, earliest bit first
    always_comb begin
        k         = (r_rem > LEN_W'(8)) ? 4'd8 : r_rem[3:0];
        shamt     = r_rem - {1'b0, k};
        wide      = {16'h0000, r_code} >> shamt;
        mask      = BYTE_W'((9'd1 << k) - 9'd1);
        chunk     = wide[7:0] & mask;
        fill      = r_nbits[2:0];
        place     = 5'(5'd16 - {2'b00, fill} - {1'b0, k});
        window    = {r_acc, 8'h00} | ({8'h00, chunk} << place);
        full_byte = ({1'b0, fill} + k) >= 4'd8;
        byte_idx  = r_nbits[NBITS_W-1:3];
        wr_en     = (r_rem != '0) && full_byte && (byte_idx < BCNT_W'(BLOCK_BYTES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_nbits <= '0;
            r_acc   <= '0;
        end else if (i_cmd.clear) begin
            r_rem   <= '0;
            r_nbits <= '0;
            r_acc   <= '0;
        end else if (i_cmd.load) begin
            r_code <= i_cmd.code;
            r_rem  <= i_cmd.len;
        end else if (r_rem != '0) begin
            r_rem   <= r_rem - {1'b0, k};
            r_nbits <= NBITS_W'(r_nbits + {6'b0, k});
            r_acc   <= full_byte ? window[7:0] : window[15:8];
        end
    end

    // completed bytes within the block go to the buffer, the partial byte stays in r_acc
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[byte_idx[AW-1:0]] <= window[15:8];
        end
        if (i_cmd.rd) begin
            r_rd_data <= r_mem[i_cmd.rd_idx[AW-1:0]];
        end
    end

    assign o_stat.nbits   = r_nbits;
    assign o_stat.busy    = (r_rem != '0);
    assign o_stat.acc     = r_acc;
    assign o_stat.rd_data = r_rd_data;

endmodule

// ----- design/nibble_huffman_bit_packer.sv -----
// Static Huffman encoder for a block of bytes coded as two 4-bit symbols each.
// A load item writes one codebook entry and does not raise busy. An encode item
// reads both codewords from the codebook memory one after the other, checks
// the block limit and then packs up to eight bits per cycle; when the limit
// check marks the block as overflowed, busy drops after the check and nothing
// is packed; an encode after overflow does not raise busy. A finish item packs
// the end-of-block code, then sends one packed byte per cycle from the byte
// buffer memory, a partial last byte from the accumulator, each result marked
// by o_valid for exactly one cycle. A finish after overflow does not raise busy
// and gives its single result in the cycle right after acceptance. A finish with
// nothing coded passes through the append and setup states and gives its single
// result in the cycle after setup.
// Results cannot be held off, so the receiver must take one every cycle.
`include "nibble_huffman_bit_packer_defines.svh"

module nibble_huffman_bit_packer #(
    parameter int BLOCK_BYTES = nhbp_pkg::BLOCK_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_entry_index,
    input  logic [15:0] i_code_bits,
    input  logic [4:0]  i_code_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output logic        o_status,
    output logic [6:0]  o_byte_count,
    output logic [9:0]  o_bit_count,
    output logic        o_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import nhbp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RD_LO  = 3'd1;
    localparam logic [2:0] ST_CHECK  = 3'd2;
    localparam logic [2:0] ST_APPEND = 3'd3;
    localparam logic [2:0] ST_SETUP  = 3'd4;
    localparam logic [2:0] ST_EMIT   = 3'd5;
    localparam logic [2:0] ST_TAIL   = 3'd6;

    localparam logic [1:0] SRC_MEM  = 2'd0;
    localparam logic [1:0] SRC_ACC  = 2'd1;
    localparam logic [1:0] SRC_ZERO = 2'd2;

    logic [2:0]         r_state;
    logic [CODE_W-1:0]  r_eof_code;
    logic [LEN_W-1:0]   r_eof_len;
    logic               r_ovf;
    logic               r_second;
    logic               r_fin;
    logic [3:0]         r_lo_nib;
    logic [ENTRY_W-1:0] r_hi;
    logic [ENTRY_W-1:0] r_lo;
    logic [BCNT_W-1:0]  r_nbytes;
    logic [BCNT_W-1:0]  r_full;
    logic [BCNT_W-1:0]  r_k;

    logic               r_o_valid;
    logic               r_o_status;
    logic [BCNT_W-1:0]  r_o_count;
    logic [NBITS_W-1:0] r_o_bits;
    logic               r_o_last;
    logic [1:0]         r_o_src;

    logic [ENTRY_W-1:0] r_tab [16];
    logic [ENTRY_W-1:0] r_tab_q;

    t_pack_cmd          pk_cmd;
    t_pack_stat         pk_stat;

    logic               accept;
    logic               cfg_wr;
    logic               tab_we;
    logic [3:0]         tab_raddr;
    logic [8:0]         chk_sum;
    logic               too_big;
    logic [BCNT_W-1:0]  full_now;
    logic [BCNT_W-1:0]  nb_raw;
    logic [BCNT_W-1:0]  nb_now;
    logic               emit_last;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EOF_LEN) ? {27'b0, r_eof_len} : {16'b0, r_eof_code};

    // codebook: at most one write and one read per cycle
    assign tab_we    = accept && (i_opcode == OP_LOAD);
    assign tab_raddr = (r_state == ST_IDLE) ? i_data_byte[7:4] : r_lo_nib;

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[i_entry_index] <= {i_code_length, i_code_bits};
        end
        r_tab_q <= r_tab[tab_raddr];
    end

    // byte limit: full bytes so far plus both code lengths and the eof length in bits
    assign chk_sum = 9'({2'b00, pk_stat.nbits[NBITS_W-1:3]}) + 9'(r_hi[ENTRY_W-1:CODE_W])
                   + 9'(r_tab_q[ENTRY_W-1:CODE_W]) + 9'(r_eof_len);
    assign too_big = chk_sum > 9'(BLOCK_BYTES - 1);

    assign full_now  = pk_stat.nbits[NBITS_W-1:3];
    assign nb_raw    = full_now + BCNT_W'(pk_stat.nbits[2:0] != 3'd0);
    assign nb_now    = (nb_raw > BCNT_W'(BLOCK_BYTES)) ? BCNT_W'(BLOCK_BYTES) : nb_raw;
    assign emit_last = (BCNT_W'(r_k + 1'b1) == r_nbytes);

    always_comb begin
        pk_cmd = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_opcode == OP_FINISH)) begin
                    if (r_ovf) begin
                        pk_cmd.clear = 1'b1;
                    end else begin
                        pk_cmd.load = 1'b1;
                        pk_cmd.code = r_eof_code;
                        pk_cmd.len  = r_eof_len;
                    end
                end
            end
            ST_CHECK: begin
                if (!too_big) begin
                    pk_cmd.load = 1'b1;
                    pk_cmd.code = r_hi[CODE_W-1:0];
                    pk_cmd.len  = r_hi[ENTRY_W-1:CODE_W];
                end
            end
            ST_APPEND: begin
                if (!pk_stat.busy && r_second) begin
                    pk_cmd.load = 1'b1;
                    pk_cmd.code = r_lo[CODE_W-1:0];
                    pk_cmd.len  = r_lo[ENTRY_W-1:CODE_W];
                end
            end
            ST_SETUP: begin
                pk_cmd.clear = (pk_stat.nbits == '0);
            end
            ST_EMIT: begin
                pk_cmd.rd     = 1'b1;
                pk_cmd.rd_idx = r_k;
            end
            ST_TAIL: begin
                pk_cmd.clear = 1'b1;
            end
            default: begin
            end
        endcase
    end

    nhbp_packer #(
        .BLOCK_BYTES(BLOCK_BYTES)
    ) u_packer (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (pk_cmd),
        .o_stat (pk_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_eof_code <= '0;
            r_eof_len  <= '0;
            r_ovf      <= 1'b0;
            r_second   <= 1'b0;
            r_fin      <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_EOF_CODE: r_eof_code <= pwdata[CODE_W-1:0];
                    REG_EOF_LEN:  r_eof_len  <= pwdata[LEN_W-1:0];
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        case (i_opcode)
                            OP_ENCODE: begin
                                if (!r_ovf) begin
                                    r_lo_nib <= i_data_byte[3:0];
                                    r_state  <= ST_RD_LO;
                                end
                            end
                            OP_FINISH: begin
                                if (r_ovf) begin
                                    // block stays raw
                                    r_ovf      <= 1'b0;
                                    r_o_valid  <= 1'b1;
                                    r_o_status <= 1'b1;
                                    r_o_count  <= BCNT_W'(BLOCK_BYTES);
                                    r_o_bits   <= '0;
                                    r_o_last   <= 1'b1;
                                    r_o_src    <= SRC_ZERO;
                                end else begin
                                    r_fin    <= 1'b1;
                                    r_second <= 1'b0;
                                    r_state  <= ST_APPEND;
                                end
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                ST_RD_LO: begin
                    r_hi    <= r_tab_q;
                    r_state <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (too_big) begin
                        r_ovf   <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_lo     <= r_tab_q;
                        r_second <= 1'b1;
                        r_fin    <= 1'b0;
                        r_state  <= ST_APPEND;
                    end
                end
                ST_APPEND: begin
                    if (!pk_stat.busy) begin
                        if (r_second) begin
                            r_second <= 1'b0;
                        end else if (r_fin) begin
                            r_state <= ST_SETUP;
                        end else begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_SETUP: begin
                    if (pk_stat.nbits == '0) begin
                        r_o_valid  <= 1'b1;
                        r_o_status <= 1'b0;
                        r_o_count  <= '0;
                        r_o_bits   <= '0;
                        r_o_last   <= 1'b1;
                        r_o_src    <= SRC_ZERO;
                        r_state    <= ST_IDLE;
                    end else begin
                        r_nbytes <= nb_now;
                        r_full   <= full_now;
                        r_k      <= '0;
                        r_state  <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    // buffer read lands with the strobe in the next cycle
                    r_o_valid  <= 1'b1;
                    r_o_status <= 1'b0;
                    r_o_count  <= r_nbytes;
                    r_o_bits   <= pk_stat.nbits;
                    r_o_last   <= emit_last;
                    r_o_src    <= (r_k < r_full) ? SRC_MEM : SRC_ACC;
                    r_k        <= BCNT_W'(r_k + 1'b1);
                    if (emit_last) begin
                        r_state <= ST_TAIL;
                    end
                end
                ST_TAIL: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        case (r_o_src)
            SRC_MEM: o_out_byte = pk_stat.rd_data;
            SRC_ACC: o_out_byte = pk_stat.acc;
            default: o_out_byte = '0;
        endcase
    end

    assign o_valid      = r_o_valid;
    assign o_status     = r_o_status;
    assign o_byte_count = r_o_count;
    assign o_bit_count  = r_o_bits;
    assign o_last       = r_o_last;

    `NHBP_ASSERT_NEXT(a_run_contiguous, o_valid && !o_last, o_valid)
    `NHBP_ASSERT_NEXT(a_gap_after_last, o_valid && o_last, !o_valid)
    `NHBP_ASSERT_IMPL(a_no_reload, pk_cmd.load, !pk_stat.busy)
    `NHBP_ASSERT_IMPL(a_count_cap, o_valid, o_byte_count <= BCNT_W'(BLOCK_BYTES))

endmodule
